### hw/rtl/dpt_pkg.sv
// Shared types, widths and register codes for the depth pixel back-projection block.
package dpt_pkg;

    // Largest frame dimension honored; larger register values are clamped to it.
    localparam int DIM_MAX = 4096;

    // Field and register widths.
    localparam int COORD_W = 12;
    localparam int BYTE_W  = 8;
    localparam int Z_W     = 3 * BYTE_W;
    localparam int DREG_W  = 13;
    localparam int F_W     = 24;
    localparam int TRIG_W  = 18;
    localparam int OUT_W   = 34;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;

    // Derived datapath widths.
    localparam int DIM_W  = $clog2(DIM_MAX + 1);
    localparam int CEN_W  = DIM_W - 1;
    localparam int DX_W   = ((CEN_W > COORD_W) ? CEN_W : COORD_W) + 1;
    localparam int M_W    = DX_W + Z_W;
    localparam int SPLIT  = 20;
    localparam int MH_W   = M_W - SPLIT;
    localparam int XL_W   = SPLIT + F_W;
    localparam int XH_W   = MH_W + F_W + 1;
    localparam int V_W    = M_W + F_W;
    localparam int FRAC_SH = 16;
    localparam int PY_W   = V_W - FRAC_SH;
    localparam int PL     = 24;
    localparam int PH_W   = PY_W - PL;
    localparam int CPL_W  = TRIG_W + PL + 1;
    localparam int CPH_W  = TRIG_W + PH_W;
    localparam int SZ_W   = TRIG_W + Z_W + 1;
    localparam int T_W    = TRIG_W + PY_W + 1;
    localparam int Z_SH   = 8;
    localparam int RT_W   = T_W - FRAC_SH;
    localparam int RS_W   = (PY_W > RT_W) ? PY_W : RT_W;

    // Rounding offsets: ties away from zero.
    localparam int RND_POS = 32768;
    localparam int RND_NEG = 32767;

    // Request queue depth between front and back.
    localparam int QD    = 2;
    localparam int QP_W  = (QD > 1) ? $clog2(QD) : 1;
    localparam int QC_W  = $clog2(QD + 1);

    // Cycles from an accepted request to its result strobe.
    localparam int DPT_LAT = 11;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_INV_FOCAL_X  = 3'd2;
    localparam logic [IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd3;
    localparam logic [IDX_W-1:0] REG_COS_TILT     = 3'd4;
    localparam logic [IDX_W-1:0] REG_SIN_TILT     = 3'd5;

    // Register reset values.
    localparam logic [DREG_W-1:0]        RST_WIDTH  = 13'd640;
    localparam logic [DREG_W-1:0]        RST_HEIGHT = 13'd480;
    localparam logic [F_W-1:0]           RST_FX     = 24'd26711;
    localparam logic [F_W-1:0]           RST_FY     = 24'd28961;
    localparam logic signed [TRIG_W-1:0] RST_COS    = 18'sd65536;
    localparam logic signed [TRIG_W-1:0] RST_SIN    = 18'sd0;

    // Configuration register set.
    typedef struct packed {
        logic [DREG_W-1:0]        width;
        logic [DREG_W-1:0]        height;
        logic [F_W-1:0]           fx;
        logic [F_W-1:0]           fy;
        logic signed [TRIG_W-1:0] cos_t;
        logic signed [TRIG_W-1:0] sin_t;
    } t_cfg;

    // One classified pixel request: centred offsets and packed depth.
    typedef struct packed {
        logic signed [DX_W-1:0] dx;
        logic signed [DX_W-1:0] ndy;
        logic [Z_W-1:0]         z;
    } t_item;

endpackage

### hw/rtl/dpt_front.sv
// Front end: accepts pixel requests, packs depth and centres the coordinates.
module dpt_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dpt_pkg::COORD_W-1:0] i_column,
    input  logic [dpt_pkg::COORD_W-1:0] i_row,
    input  logic [dpt_pkg::BYTE_W-1:0]  i_depth_low_byte,
    input  logic [dpt_pkg::BYTE_W-1:0]  i_depth_mid_byte,
    input  logic [dpt_pkg::BYTE_W-1:0]  i_depth_high_byte,
    input  dpt_pkg::t_cfg              i_cfg,
    input  logic                       i_q_full,
    output logic                       o_busy,
    output logic                       o_push,
    output dpt_pkg::t_item             o_item
);
    import dpt_pkg::*;

    logic             r_valid;
    logic             n_valid;
    t_item            r_item;
    t_item            n_item;
    logic             accept;
    logic [DIM_W-1:0] w_clamp;
    logic [DIM_W-1:0] h_clamp;
    logic [CEN_W-1:0] cx;
    logic [CEN_W-1:0] cy;

    // Handshake: the staging register drains into the queue unless it is full.
    assign o_busy = r_valid && i_q_full;
    assign o_push = r_valid && !i_q_full;
    assign accept = i_start && !o_busy;
    assign o_item = r_item;

    // Frame centres with the dimension clamped to the supported maximum.
    always_comb begin
        w_clamp = (32'(i_cfg.width) > 32'(DIM_MAX)) ? DIM_W'(DIM_MAX) : DIM_W'(i_cfg.width);
        h_clamp = (32'(i_cfg.height) > 32'(DIM_MAX)) ? DIM_W'(DIM_MAX) : DIM_W'(i_cfg.height);
        cx = w_clamp[DIM_W-1:1];
        cy = h_clamp[DIM_W-1:1];
    end

    // Classify the pixel: depth word and signed offsets from the centre.
    always_comb begin
        n_item.z   = {i_depth_high_byte, i_depth_mid_byte, i_depth_low_byte};
        n_item.dx  = $signed(DX_W'(i_column) - DX_W'(cx));
        n_item.ndy = $signed(DX_W'(cy) - DX_W'(i_row));
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

### hw/rtl/dpt_queue.sv
// Short request queue between the front end and the arithmetic back end.
module dpt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dpt_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output dpt_pkg::t_item o_item
);
    import dpt_pkg::*;

    t_item            r_mem [QD];
    logic [QP_W-1:0]  r_wr;
    logic [QP_W-1:0]  r_rd;
    logic [QC_W-1:0]  r_count;
    logic [QC_W-1:0]  n_count;
    logic             do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QC_W'(QD));
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count + QC_W'(i_push) - QC_W'(do_pop);
    end

    // Pointer and count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= (32'(r_wr) == QD - 1) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (32'(r_rd) == QD - 1) ? '0 : r_rd + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

### hw/rtl/dpt_back.sv
// Back end: projection and tilt rotation pipeline with rounding and saturation.
module dpt_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  dpt_pkg::t_item                 i_item,
    input  dpt_pkg::t_cfg                  i_cfg,
    output logic                           o_pop,
    output logic                           o_valid,
    output logic signed [dpt_pkg::OUT_W-1:0] o_point_x,
    output logic signed [dpt_pkg::OUT_W-1:0] o_point_y,
    output logic signed [dpt_pkg::OUT_W-1:0] o_point_z
);
    import dpt_pkg::*;

    // Clamp a rounded value into the output range.
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [RS_W-1:0] r);
        logic [RS_W-OUT_W:0] hi;
        hi = r[RS_W-1:OUT_W-1];
        if ((&hi) || !(|hi)) begin
            return r[OUT_W-1:0];
        end else if (r[RS_W-1]) begin
            return {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            return {1'b0, {(OUT_W-1){1'b1}}};
        end
    endfunction

    logic                    r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic signed [DX_W-1:0]  r_dx0, r_ndy0;
    logic [Z_W-1:0]          r_z0, r_z1, r_z2, r_z3, r_z4;
    logic signed [M_W-1:0]   r_mx1, r_my1;
    logic [XL_W-1:0]         r_xl2, r_yl2;
    logic signed [XH_W-1:0]  r_xh2, r_yh2;
    logic signed [V_W-1:0]   r_vx3, r_vy3;
    logic [OUT_W-1:0]        r_px4, r_px5, r_px6, r_px7;
    logic signed [PY_W-1:0]  r_py4;
    logic signed [CPL_W-1:0] r_cpl5, r_spl5;
    logic signed [CPH_W-1:0] r_cph5, r_sph5;
    logic signed [SZ_W-1:0]  r_sz5, r_cz5, r_sz6, r_cz6;
    logic signed [T_W-1:0]   r_cp6, r_sp6, r_ty7, r_tz7;

    logic signed [V_W-1:0]   vx_adj, vy_adj;
    logic signed [PY_W-1:0]  rx;
    logic signed [T_W-1:0]   ty_adj, tz_adj;
    logic signed [RT_W-1:0]  ry, rz;

    // The back end never stalls, so it takes every queued request.
    assign o_pop = i_valid;

    // Rounding of the lateral and vertical projections.
    always_comb begin
        vx_adj = r_vx3 + (r_vx3[V_W-1] ? V_W'(RND_NEG) : V_W'(RND_POS));
        vy_adj = r_vy3 + (r_vy3[V_W-1] ? V_W'(RND_NEG) : V_W'(RND_POS));
        rx     = vx_adj[V_W-1:FRAC_SH];
    end

    // Rounding of the rotated coordinates.
    always_comb begin
        ty_adj = r_ty7 + (r_ty7[T_W-1] ? T_W'(RND_NEG) : T_W'(RND_POS));
        tz_adj = r_tz7 + (r_tz7[T_W-1] ? T_W'(RND_NEG) : T_W'(RND_POS));
        ry     = ty_adj[T_W-1:FRAC_SH];
        rz     = tz_adj[T_W-1:FRAC_SH];
    end

    // Valid chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_v6    <= 1'b0;
            r_v7    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v0    <= i_valid;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            r_v6    <= r_v5;
            r_v7    <= r_v6;
            o_valid <= r_v7;
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        // Stage 0: take the request from the queue.
        r_dx0  <= i_item.dx;
        r_ndy0 <= i_item.ndy;
        r_z0   <= i_item.z;

        // Stage 1: offset times depth.
        r_mx1 <= $signed(r_dx0) * $signed({1'b0, r_z0});
        r_my1 <= $signed(r_ndy0) * $signed({1'b0, r_z0});
        r_z1  <= r_z0;

        // Stage 2: partial products with the reciprocal focal lengths.
        r_xl2 <= r_mx1[SPLIT-1:0] * i_cfg.fx;
        r_yl2 <= r_my1[SPLIT-1:0] * i_cfg.fy;
        r_xh2 <= $signed(r_mx1[M_W-1:SPLIT]) * $signed({1'b0, i_cfg.fx});
        r_yh2 <= $signed(r_my1[M_W-1:SPLIT]) * $signed({1'b0, i_cfg.fy});
        r_z2  <= r_z1;

        // Stage 3: combine the partial products.
        r_vx3 <= (V_W'(r_xh2) <<< SPLIT) + V_W'({1'b0, r_xl2});
        r_vy3 <= (V_W'(r_yh2) <<< SPLIT) + V_W'({1'b0, r_yl2});
        r_z3  <= r_z2;

        // Stage 4: round to millimetre Q.8; the lateral value saturates here.
        r_px4 <= sat_out(RS_W'(rx));
        r_py4 <= vy_adj[V_W-1:FRAC_SH];
        r_z4  <= r_z3;

        // Stage 5: rotation partial products.
        r_cpl5 <= $signed(i_cfg.cos_t) * $signed({1'b0, r_py4[PL-1:0]});
        r_cph5 <= $signed(i_cfg.cos_t) * $signed(r_py4[PY_W-1:PL]);
        r_spl5 <= $signed(i_cfg.sin_t) * $signed({1'b0, r_py4[PL-1:0]});
        r_sph5 <= $signed(i_cfg.sin_t) * $signed(r_py4[PY_W-1:PL]);
        r_sz5  <= $signed(i_cfg.sin_t) * $signed({1'b0, r_z4});
        r_cz5  <= $signed(i_cfg.cos_t) * $signed({1'b0, r_z4});
        r_px5  <= r_px4;

        // Stage 6: assemble cos*y and sin*y.
        r_cp6 <= (T_W'(r_cph5) <<< PL) + T_W'(r_cpl5);
        r_sp6 <= (T_W'(r_sph5) <<< PL) + T_W'(r_spl5);
        r_sz6 <= r_sz5;
        r_cz6 <= r_cz5;
        r_px6 <= r_px5;

        // Stage 7: add the depth terms, where z0 is minus depth in Q.8.
        r_ty7 <= r_cp6 - (T_W'(r_sz6) <<< Z_SH);
        r_tz7 <= -(T_W'(r_cz6) <<< Z_SH) - r_sp6;
        r_px7 <= r_px6;

        // Stage 8: round, saturate and present the result.
        o_point_x <= r_px7;
        o_point_y <= sat_out(RS_W'(ry));
        o_point_z <= sat_out(RS_W'(rz));
    end

endmodule

### hw/rtl/depth_pixel_to_tilted_point_top.sv
// Top level: configuration registers, front end, request queue and back end.
//
// Turns one depth pixel per clock into a tilted 3D point (signed Q25.8 mm).
// A request is taken on every cycle with start high and busy low. Its result
// is on o_point_x/y/z with o_valid high for one cycle, and results come in
// request order. Each request passes the front-end staging register, the
// request queue and the back-end pipeline, whose stages are a capture stage,
// two multiplier stages and a combine stage for the projection, a rounding
// stage, one multiplier stage and two add stages for the rotation, and a
// final rounding and saturation stage. Busy only rises if the request queue
// fills, which the free-running back end never lets happen, so a new pixel
// may be given every cycle. Results cannot be held off. Write registers only
// while no request is in flight.
module depth_pixel_to_tilted_point_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dpt_pkg::COORD_W-1:0]       i_column,
    input  logic [dpt_pkg::COORD_W-1:0]       i_row,
    input  logic [dpt_pkg::BYTE_W-1:0]        i_depth_low_byte,
    input  logic [dpt_pkg::BYTE_W-1:0]        i_depth_mid_byte,
    input  logic [dpt_pkg::BYTE_W-1:0]        i_depth_high_byte,
    input  logic                              i_cfg_we,
    input  logic [dpt_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [dpt_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                              o_valid,
    output logic signed [dpt_pkg::OUT_W-1:0]  o_point_x,
    output logic signed [dpt_pkg::OUT_W-1:0]  o_point_y,
    output logic signed [dpt_pkg::OUT_W-1:0]  o_point_z
);
    import dpt_pkg::*;

    t_cfg  r_cfg;
    t_cfg  n_cfg;
    t_item front_item;
    t_item q_item;
    logic  front_push;
    logic  q_full;
    logic  q_valid;
    logic  back_pop;

    // Register write decode; unknown indexes are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH:  n_cfg.width  = i_cfg_data[DREG_W-1:0];
                REG_IMAGE_HEIGHT: n_cfg.height = i_cfg_data[DREG_W-1:0];
                REG_INV_FOCAL_X:  n_cfg.fx     = i_cfg_data[F_W-1:0];
                REG_INV_FOCAL_Y:  n_cfg.fy     = i_cfg_data[F_W-1:0];
                REG_COS_TILT:     n_cfg.cos_t  = $signed(i_cfg_data[TRIG_W-1:0]);
                REG_SIN_TILT:     n_cfg.sin_t  = $signed(i_cfg_data[TRIG_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.fx     <= RST_FX;
            r_cfg.fy     <= RST_FY;
            r_cfg.cos_t  <= RST_COS;
            r_cfg.sin_t  <= RST_SIN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Request intake and classification.
    dpt_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_depth_low_byte  (i_depth_low_byte),
        .i_depth_mid_byte  (i_depth_mid_byte),
        .i_depth_high_byte (i_depth_high_byte),
        .i_cfg             (r_cfg),
        .i_q_full          (q_full),
        .o_busy            (busy),
        .o_push            (front_push),
        .o_item            (front_item)
    );

    // Decoupling queue.
    dpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .i_pop   (back_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_item  (q_item)
    );

    // Arithmetic pipeline.
    dpt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_item    (q_item),
        .i_cfg     (r_cfg),
        .o_pop     (back_pop),
        .o_valid   (o_valid),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y),
        .o_point_z (o_point_z)
    );

endmodule

### hw/rtl/dpt_checker.sv
// Port-level checks for the depth pixel back-projection block, bound to the top level.
module dpt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [dpt_pkg::BYTE_W-1:0]        i_depth_low_byte,
    input logic [dpt_pkg::BYTE_W-1:0]        i_depth_mid_byte,
    input logic [dpt_pkg::BYTE_W-1:0]        i_depth_high_byte,
    input logic                              o_valid,
    input logic signed [dpt_pkg::OUT_W-1:0]  o_point_x,
    input logic signed [dpt_pkg::OUT_W-1:0]  o_point_y,
    input logic signed [dpt_pkg::OUT_W-1:0]  o_point_z
);
    import dpt_pkg::*;

    logic accept;
    logic zero_depth;

    assign accept     = start && !busy;
    assign zero_depth = (i_depth_low_byte == '0) && (i_depth_mid_byte == '0) &&
                        (i_depth_high_byte == '0);

    // The back end drains the queue every cycle, so busy never rises.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised although the back end never stalls");

    // Every accepted request yields a result after the fixed latency.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##DPT_LAT o_valid) else $error("result missing after request");

    // No result appears without a matching request.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept && i_rst_n, DPT_LAT))
        else $error("result without a request");

    // A pixel with zero depth projects to the origin.
    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && zero_depth) |-> ##DPT_LAT
        (o_valid && (o_point_x == '0) && (o_point_y == '0) && (o_point_z == '0)))
        else $error("zero depth did not give the origin");

endmodule

bind depth_pixel_to_tilted_point_top dpt_checker u_dpt_checker (.*);
